// ===== hdl/smbmi_pkg.sv =====
`default_nettype none

package smbmi_pkg;

  localparam int TIMER_BITS = 24;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_RESULT = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic KIND_ACCESS = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_BUS_ERR = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_SKIPPED = 2'd3;

  localparam logic CFG_RETRY_LIMIT = 1'b0;
  localparam logic CFG_POLL_INTERVAL = 1'b1;

  localparam logic [4:0] PH_IDLE = 5'd0;
  localparam logic [4:0] PH_FLAG = 5'd1;
  localparam logic [4:0] PH_CLR = 5'd2;
  localparam logic [4:0] PH_CMD = 5'd3;
  localparam logic [4:0] PH_MSG0 = 5'd4;
  localparam logic [4:0] PH_SET = 5'd8;
  localparam logic [4:0] PH_POLL = 5'd9;
  localparam logic [4:0] PH_OUT0 = 5'd11;
  localparam logic [4:0] PH_ACK = 5'd15;
  localparam logic [4:0] PH_CODE = 5'd16;

  localparam logic [7:0] REG_STATUS = 8'h02;
  localparam logic [7:0] REG_OUT0 = 8'h31;
  localparam logic [7:0] REG_FW_CODE = 8'h37;
  localparam logic [7:0] REG_CMD = 8'h38;
  localparam logic [7:0] REG_IN0 = 8'h39;
  localparam logic [7:0] REG_FLAG = 8'h3F;
  localparam logic [7:0] REG_DOORBELL = 8'h40;

  localparam logic [7:0] FLAG_VALUE = 8'h80;
  localparam logic [7:0] ALERT_CLEAR = 8'h02;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  slave_addr;
    logic [7:0]  command;
    logic [31:0] msg_in;
    logic        has_msg_in;
    logic        want_msg_out;
    logic [23:0] timeout_ticks;
    logic        soc_low_power;
    logic        bus_ok;
    logic [7:0]  bus_rdata;
  } in_beat_t;

  typedef struct packed {
    logic        out_kind;
    logic        bus_is_read;
    logic [6:0]  bus_slave;
    logic [7:0]  bus_reg;
    logic [7:0]  bus_wdata;
    logic [1:0]  done_status;
    logic [7:0]  fw_code;
    logic [31:0] msg_out;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== hdl/smbus_mailbox_initiator_top.sv =====
// Mailbox command sequencer for a byte-register target device.
// Input channel (in_valid/in_ready/in_data): start, bus-result and tick beats.
// A start beat latches the target, command, message and timeout and produces
// the first access, or a skipped completion if soc_low_power. Each bus-result
// beat reports the last request's outcome and usually yields the next request
// or a completion. Tick beats count the poll interval and timeout while polling.
// Output channel (out_valid/out_ready/out_data): access requests and one
// completion per command. Each input beat yields zero or one output beat.
// Each output beat is registered: it is valid in the cycle after its input beat is taken.
// Throughput: one input beat per cycle while in_ready is high; all state
// updates are combinational between the state registers and output register.
// Stall: the output register holds its beat while out_ready is low; in_ready
// stays high while that register is empty or being drained in the same cycle.
// Reset (rst, synchronous): idle, retry limit 3, poll interval 5000 ticks,
// output empty. Configuration writes (cfg_we) take effect on the next cycle.
`default_nettype none

module smbus_mailbox_initiator_top (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire  smbmi_pkg::in_beat_t in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output smbmi_pkg::out_beat_t     out_data,
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire  [15:0]              cfg_wdata
);

  logic [2:0]  retry_limit;
  logic [15:0] poll_interval_ticks;

  logic [4:0]  phase, phase_next;
  logic [2:0]  tries_left, tries_left_next;
  logic [6:0]  held_slave, held_slave_next;
  logic [7:0]  held_command, held_command_next;
  logic [31:0] held_message, held_message_next;
  logic [1:0]  held_flags, held_flags_next;
  logic [smbmi_pkg::TIMER_BITS-1:0] timeout_limit, timeout_limit_next;
  logic [smbmi_pkg::TIMER_BITS-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [15:0] interval_count, interval_count_next;
  logic        waiting_interval, waiting_interval_next;
  logic [31:0] assembled_output, assembled_output_next;

  logic                 accept;
  logic                 res_valid;
  smbmi_pkg::out_beat_t res;
  logic [2:0]           fresh_tries;
  logic [15:0]          fresh_interval;
  logic [31:0]          timeout_wide;
  logic [1:0]           out_idx;

  function automatic smbmi_pkg::out_beat_t access(input logic [4:0] p,
                                                  input logic [6:0] slave,
                                                  input logic [7:0] cmd,
                                                  input logic [31:0] msg);
    smbmi_pkg::out_beat_t o;
    logic [1:0] idx;
    o = '0;
    idx = 2'(p - smbmi_pkg::PH_MSG0);
    o.out_kind = smbmi_pkg::KIND_ACCESS;
    o.bus_slave = slave;
    if (p == smbmi_pkg::PH_FLAG) begin
      o.bus_reg = smbmi_pkg::REG_FLAG;
      o.bus_wdata = smbmi_pkg::FLAG_VALUE;
    end else if (p == smbmi_pkg::PH_CLR) begin
      o.bus_reg = smbmi_pkg::REG_DOORBELL;
    end else if (p == smbmi_pkg::PH_CMD) begin
      o.bus_reg = smbmi_pkg::REG_CMD;
      o.bus_wdata = cmd;
    end else if (p >= smbmi_pkg::PH_MSG0 && p < smbmi_pkg::PH_SET) begin
      o.bus_reg = smbmi_pkg::REG_IN0 + 8'(idx);
      o.bus_wdata = msg[8*idx +: 8];
    end else if (p == smbmi_pkg::PH_SET) begin
      o.bus_reg = smbmi_pkg::REG_DOORBELL;
      o.bus_wdata = 8'h01;
    end else if (p == smbmi_pkg::PH_POLL) begin
      o.bus_is_read = 1'b1;
      o.bus_reg = smbmi_pkg::REG_STATUS;
    end else if (p >= smbmi_pkg::PH_OUT0 && p < smbmi_pkg::PH_ACK) begin
      o.bus_is_read = 1'b1;
      o.bus_reg = smbmi_pkg::REG_OUT0 + 8'(2'(p - smbmi_pkg::PH_OUT0));
    end else if (p == smbmi_pkg::PH_ACK) begin
      o.bus_reg = smbmi_pkg::REG_STATUS;
      o.bus_wdata = smbmi_pkg::ALERT_CLEAR;
    end else begin
      o.bus_is_read = 1'b1;
      o.bus_reg = smbmi_pkg::REG_FW_CODE;
    end
    return o;
  endfunction

  function automatic smbmi_pkg::out_beat_t completion(input logic [1:0] status,
                                                      input logic [7:0] code,
                                                      input logic [31:0] msg);
    smbmi_pkg::out_beat_t o;
    o = '0;
    o.out_kind = smbmi_pkg::KIND_DONE;
    o.done_status = status;
    o.fw_code = code;
    o.msg_out = msg;
    return o;
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign fresh_tries = (retry_limit != 3'd0) ? retry_limit : 3'd1;
  assign fresh_interval = (poll_interval_ticks != 16'd0) ? poll_interval_ticks : 16'd1;
  assign timeout_wide = 32'(in_data.timeout_ticks);
  assign out_idx = 2'(phase - smbmi_pkg::PH_OUT0);

  always_comb begin
    phase_next = phase;
    tries_left_next = tries_left;
    held_slave_next = held_slave;
    held_command_next = held_command;
    held_message_next = held_message;
    held_flags_next = held_flags;
    timeout_limit_next = timeout_limit;
    elapsed_ticks_next = elapsed_ticks;
    interval_count_next = interval_count;
    waiting_interval_next = waiting_interval;
    assembled_output_next = assembled_output;
    res_valid = 1'b0;
    res = '0;
    if (accept) begin
      unique case (in_data.req_type)
        smbmi_pkg::REQ_START: begin
          if (phase == smbmi_pkg::PH_IDLE) begin
            res_valid = 1'b1;
            if (in_data.soc_low_power) begin
              res = completion(smbmi_pkg::ST_SKIPPED, 8'd0, 32'd0);
              tries_left_next = 3'd0;
            end else begin
              held_slave_next = in_data.slave_addr;
              held_command_next = in_data.command;
              held_message_next = in_data.msg_in;
              held_flags_next = {in_data.want_msg_out, in_data.has_msg_in};
              if (timeout_wide > 32'(smbmi_pkg::TMAX)) begin
                timeout_limit_next = smbmi_pkg::TMAX;
              end else begin
                timeout_limit_next = smbmi_pkg::TIMER_BITS'(timeout_wide);
              end
              elapsed_ticks_next = '0;
              interval_count_next = 16'd0;
              waiting_interval_next = 1'b0;
              assembled_output_next = 32'd0;
              phase_next = smbmi_pkg::PH_FLAG;
              tries_left_next = fresh_tries;
              res = access(smbmi_pkg::PH_FLAG, in_data.slave_addr, in_data.command,
                           in_data.msg_in);
            end
          end
        end
        smbmi_pkg::REQ_RESULT: begin
          if (phase != smbmi_pkg::PH_IDLE && !waiting_interval) begin
            res_valid = 1'b1;
            res = access(phase, held_slave, held_command, held_message);
            if (!in_data.bus_ok) begin
              if (tries_left > 3'd1) begin
                tries_left_next = tries_left - 3'd1;
              end else begin
                res = completion(smbmi_pkg::ST_BUS_ERR, 8'd0, 32'd0);
                phase_next = smbmi_pkg::PH_IDLE;
                tries_left_next = 3'd0;
              end
            end else begin
              tries_left_next = fresh_tries;
              priority if (phase == smbmi_pkg::PH_CMD) begin
                phase_next = held_flags[0] ? smbmi_pkg::PH_MSG0 : smbmi_pkg::PH_SET;
              end else if (phase == smbmi_pkg::PH_SET) begin
                elapsed_ticks_next = '0;
                phase_next = smbmi_pkg::PH_POLL;
              end else if (phase == smbmi_pkg::PH_POLL) begin
                if (in_data.bus_rdata[1]) begin
                  assembled_output_next = 32'd0;
                  phase_next = held_flags[1] ? smbmi_pkg::PH_OUT0 : smbmi_pkg::PH_ACK;
                end else begin
                  res_valid = 1'b0;
                  tries_left_next = tries_left;
                  waiting_interval_next = 1'b1;
                  interval_count_next = fresh_interval;
                end
              end else if (phase >= smbmi_pkg::PH_OUT0 && phase < smbmi_pkg::PH_ACK) begin
                assembled_output_next = assembled_output
                                      | (32'(in_data.bus_rdata) << (8 * out_idx));
                phase_next = phase + 5'd1;
              end else if (phase == smbmi_pkg::PH_CODE) begin
                res = completion(smbmi_pkg::ST_DONE, in_data.bus_rdata,
                                 held_flags[1] ? assembled_output : 32'd0);
                phase_next = smbmi_pkg::PH_IDLE;
                tries_left_next = 3'd0;
              end else if (phase < smbmi_pkg::PH_CODE) begin
                phase_next = phase + 5'd1;
              end else begin
                res_valid = 1'b0;
                tries_left_next = tries_left;
              end
              if (res_valid && res.out_kind == smbmi_pkg::KIND_ACCESS) begin
                res = access(phase_next, held_slave, held_command, held_message);
              end
            end
          end
        end
        smbmi_pkg::REQ_TICK: begin
          if (phase == smbmi_pkg::PH_POLL) begin
            if (elapsed_ticks != smbmi_pkg::TMAX) begin
              elapsed_ticks_next = elapsed_ticks + 1'b1;
            end
            if (waiting_interval) begin
              if (interval_count != 16'd0) begin
                interval_count_next = interval_count - 16'd1;
              end
              if (interval_count_next == 16'd0) begin
                waiting_interval_next = 1'b0;
                res_valid = 1'b1;
                if (timeout_limit != '0 && elapsed_ticks_next >= timeout_limit) begin
                  res = completion(smbmi_pkg::ST_TIMEOUT, 8'd0, 32'd0);
                  phase_next = smbmi_pkg::PH_IDLE;
                  tries_left_next = 3'd0;
                end else begin
                  res = access(smbmi_pkg::PH_POLL, held_slave, held_command,
                               held_message);
                  tries_left_next = fresh_tries;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= 3'd3;
      poll_interval_ticks <= 16'd5000;
      phase <= smbmi_pkg::PH_IDLE;
      tries_left <= 3'd0;
      held_slave <= 7'd0;
      held_command <= 8'd0;
      held_message <= 32'd0;
      held_flags <= 2'd0;
      timeout_limit <= '0;
      elapsed_ticks <= '0;
      interval_count <= 16'd0;
      waiting_interval <= 1'b0;
      assembled_output <= 32'd0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          smbmi_pkg::CFG_RETRY_LIMIT: retry_limit <= cfg_wdata[2:0];
          smbmi_pkg::CFG_POLL_INTERVAL: poll_interval_ticks <= cfg_wdata;
          default: begin
          end
        endcase
      end
      phase <= phase_next;
      tries_left <= tries_left_next;
      held_slave <= held_slave_next;
      held_command <= held_command_next;
      held_message <= held_message_next;
      held_flags <= held_flags_next;
      timeout_limit <= timeout_limit_next;
      elapsed_ticks <= elapsed_ticks_next;
      interval_count <= interval_count_next;
      waiting_interval <= waiting_interval_next;
      assembled_output <= assembled_output_next;
      if (accept && res_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data <= res;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == smbmi_pkg::PH_IDLE |-> !waiting_interval && tries_left == 3'd0)
    else $error("idle with live retry or interval state");

  a_busy_budget: assert property (@(posedge clk) disable iff (rst)
    phase != smbmi_pkg::PH_IDLE |-> tries_left != 3'd0)
    else $error("busy with no attempts left");

  a_wait_in_poll: assert property (@(posedge clk) disable iff (rst)
    waiting_interval |-> phase == smbmi_pkg::PH_POLL)
    else $error("interval wait outside polling");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_kind == smbmi_pkg::KIND_DONE
      && out_data.done_status != smbmi_pkg::ST_DONE
      |-> out_data.fw_code == 8'd0 && out_data.msg_out == 32'd0)
    else $error("failed completion carries data");

endmodule

`default_nettype wire
